// ----- src/fetb_pkg.sv -----
// fetb_pkg: types and constants for the Ethernet frame builder with CRC-32.
// No dependencies.
`default_nettype none

package fetb_pkg;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] byte_kind;
    logic       run_last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_byte;
    logic       first_byte;
  } q_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef struct packed {
    logic [47:0] dest_mac;
    logic [47:0] src_mac;
    logic [15:0] ether_type;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_DST,
    ST_SRC,
    ST_ETY,
    ST_PAY,
    ST_FCS,
    ST_PAD
  } st_t;

  localparam logic [1:0] CFG_DEST_MAC   = 2'd0;
  localparam logic [1:0] CFG_SRC_MAC    = 2'd1;
  localparam logic [1:0] CFG_ETHER_TYPE = 2'd2;

  localparam logic [2:0] KIND_PREAMBLE = 3'd0;
  localparam logic [2:0] KIND_HEADER   = 3'd1;
  localparam logic [2:0] KIND_PAYLOAD  = 3'd2;
  localparam logic [2:0] KIND_FCS      = 3'd3;
  localparam logic [2:0] KIND_IDLE     = 3'd4;

  localparam logic [63:0] PREAMBLE       = 64'hFB55_5555_5555_55D5;
  localparam logic [31:0] CRC_POLY_REFL  = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT       = 32'hFFFF_FFFF;
  localparam logic [7:0]  IDLE_BYTE      = 8'h07;
  localparam logic [15:0] ETHER_TYPE_RST = 16'hAEFE;

endpackage

`default_nettype wire

// ----- src/fetb_fifo.sv -----
// fetb_fifo: small register queue between the front and back sections.
// Depends on fetb_pkg for the status struct.
`default_nettype none

module fetb_fifo #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [WIDTH-1:0]      push_data,
  input  logic                  pop,
  output logic [WIDTH-1:0]      head,
  output fetb_pkg::q_status_t   status
);
  import fetb_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign status.empty = (count == '0);
  assign status.full  = (count == CW'(DEPTH));
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- src/fetb_front.sv -----
// fetb_front: input transaction acceptance and frame-start classification.
// Depends on fetb_pkg; feeds fetb_fifo.
`default_nettype none

module fetb_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  fetb_pkg::in_item_t   in_item,
  output logic                 in_stall,
  input  fetb_pkg::q_status_t  q_status,
  output logic                 push,
  output fetb_pkg::q_entry_t   push_entry
);
  import fetb_pkg::*;

  logic in_frame;

  assign in_stall               = q_status.full;
  assign push                   = in_valid && !q_status.full;
  assign push_entry.payload_byte = in_item.payload_byte;
  assign push_entry.last_byte    = in_item.last_byte;
  assign push_entry.first_byte   = !in_frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
    end else if (push) begin
      in_frame <= !in_item.last_byte;
    end
  end

endmodule

`default_nettype wire

// ----- src/fetb_back.sv -----
// fetb_back: byte sequencer that emits preamble, header, payload, FCS and padding.
// Depends on fetb_pkg; drains fetb_fifo and owns the output register.
`default_nettype none

module fetb_back (
  input  logic                 clk,
  input  logic                 rst,
  input  fetb_pkg::cfg_t       cfg,
  input  fetb_pkg::q_entry_t   q_head,
  input  fetb_pkg::q_status_t  q_status,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output fetb_pkg::out_item_t  out_item
);
  import fetb_pkg::*;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY_REFL) : (r >> 1);
    end
    return r;
  endfunction

  st_t         state;
  st_t         state_next;
  logic [2:0]  cnt;
  logic [2:0]  cnt_next;
  logic [31:0] crc;
  logic [1:0]  len;
  logic [1:0]  len_inc;
  logic [7:0]  held_byte;
  logic        held_last;
  logic        adv;
  logic        emit;
  logic        fire;
  logic        crc_on;
  logic        start;
  out_item_t   e_item;
  logic [31:0] fcs;

  assign adv     = !out_valid || !out_stall;
  assign fire    = emit && adv;
  assign len_inc = len + 2'd1;
  assign fcs     = ~crc;
  assign start   = (state == ST_IDLE) && q_head.first_byte;

  always_comb begin
    emit   = 1'b0;
    pop    = 1'b0;
    crc_on = 1'b0;
    e_item = '{out_byte: 8'd0, byte_kind: KIND_PREAMBLE, run_last: 1'b0};
    case (state)
      ST_IDLE: begin
        if (!q_status.empty) begin
          emit = 1'b1;
          pop  = adv;
          if (q_head.first_byte) begin
            e_item.out_byte = PREAMBLE[63:56];
          end else begin
            e_item.out_byte  = q_head.payload_byte;
            e_item.byte_kind = KIND_PAYLOAD;
            e_item.run_last  = !q_head.last_byte;
            crc_on           = 1'b1;
          end
        end
      end
      ST_PRE: begin
        emit            = 1'b1;
        e_item.out_byte = 8'(PREAMBLE >> {3'(3'd7 - cnt), 3'b000});
      end
      ST_DST: begin
        emit             = 1'b1;
        crc_on           = 1'b1;
        e_item.byte_kind = KIND_HEADER;
        e_item.out_byte  = 8'(cfg.dest_mac >> {3'(3'd5 - cnt), 3'b000});
      end
      ST_SRC: begin
        emit             = 1'b1;
        crc_on           = 1'b1;
        e_item.byte_kind = KIND_HEADER;
        e_item.out_byte  = 8'(cfg.src_mac >> {3'(3'd5 - cnt), 3'b000});
      end
      ST_ETY: begin
        emit             = 1'b1;
        crc_on           = 1'b1;
        e_item.byte_kind = KIND_HEADER;
        e_item.out_byte  = cnt[0] ? cfg.ether_type[7:0] : cfg.ether_type[15:8];
      end
      ST_PAY: begin
        emit             = 1'b1;
        crc_on           = 1'b1;
        e_item.byte_kind = KIND_PAYLOAD;
        e_item.out_byte  = held_byte;
        e_item.run_last  = !held_last;
      end
      ST_FCS: begin
        emit             = 1'b1;
        e_item.byte_kind = KIND_FCS;
        e_item.out_byte  = 8'(fcs >> {cnt[1:0], 3'b000});
        e_item.run_last  = (cnt == 3'd3) && (len_inc == 2'd0);
      end
      ST_PAD: begin
        emit             = 1'b1;
        e_item.byte_kind = KIND_IDLE;
        e_item.out_byte  = IDLE_BYTE;
        e_item.run_last  = (len_inc == 2'd0);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    if (fire) begin
      cnt_next = cnt + 3'd1;
      case (state)
        ST_IDLE: begin
          cnt_next = q_head.first_byte ? 3'd1 : 3'd0;
          if (q_head.first_byte) begin
            state_next = ST_PRE;
          end else if (q_head.last_byte) begin
            state_next = ST_FCS;
          end
        end
        ST_PRE: begin
          if (cnt == 3'd7) begin
            state_next = ST_DST;
            cnt_next   = 3'd0;
          end
        end
        ST_DST: begin
          if (cnt == 3'd5) begin
            state_next = ST_SRC;
            cnt_next   = 3'd0;
          end
        end
        ST_SRC: begin
          if (cnt == 3'd5) begin
            state_next = ST_ETY;
            cnt_next   = 3'd0;
          end
        end
        ST_ETY: begin
          if (cnt == 3'd1) begin
            state_next = ST_PAY;
            cnt_next   = 3'd0;
          end
        end
        ST_PAY: begin
          state_next = held_last ? ST_FCS : ST_IDLE;
          cnt_next   = 3'd0;
        end
        ST_FCS: begin
          if (cnt == 3'd3) begin
            state_next = (len_inc == 2'd0) ? ST_IDLE : ST_PAD;
            cnt_next   = 3'd0;
          end
        end
        ST_PAD: begin
          if (len_inc == 2'd0) begin
            state_next = ST_IDLE;
          end
          cnt_next = 3'd0;
        end
        default: begin
          state_next = ST_IDLE;
          cnt_next   = 3'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= 3'd0;
      crc       <= CRC_INIT;
      len       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (adv) begin
        out_valid <= emit;
      end
      if (fire) begin
        if (start) begin
          crc <= CRC_INIT;
          len <= 2'd1;
        end else begin
          len <= len_inc;
          if (crc_on) begin
            crc <= crc_byte(crc, e_item.out_byte);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item <= e_item;
    end
    if (fire && start) begin
      held_byte <= q_head.payload_byte;
      held_last <= q_head.last_byte;
    end
  end

endmodule

`default_nettype wire

// ----- src/ethernet_frame_builder_crc32.sv -----
// Ethernet transmit framer with IEEE CRC-32 FCS. One output byte leaves per cycle
// from the byte sequencer while out_stall does not hold it, so throughput is set by
// output bytes: a byte inside a frame gives one output byte, the first byte of a frame
// gives 23 (8 preamble, 14 header, the payload byte) and the last byte gives 5 to 8
// (payload, 4 FCS bytes, 0 to 3 idle bytes). Input transactions are taken into a
// QUEUE_DEPTH entry queue while it has room, independently of output stall.
// Depends on fetb_pkg, fetb_front, fetb_fifo and fetb_back.
`default_nettype none

module ethernet_frame_builder_crc32 #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [1:0]           cfg_index,
  input  logic [47:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  fetb_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output fetb_pkg::out_item_t  out_item
);
  import fetb_pkg::*;

  cfg_t      cfg;
  q_status_t q_status;
  q_entry_t  push_entry;
  q_entry_t  q_head;
  logic      push;
  logic      pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dest_mac   <= 48'd0;
      cfg.src_mac    <= 48'd0;
      cfg.ether_type <= ETHER_TYPE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_DEST_MAC:   cfg.dest_mac   <= cfg_data;
        CFG_SRC_MAC:    cfg.src_mac    <= cfg_data;
        CFG_ETHER_TYPE: cfg.ether_type <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  fetb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .in_stall   (in_stall),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  fetb_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH ($bits(q_entry_t))
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_entry),
    .pop       (pop),
    .head      (q_head),
    .status    (q_status)
  );

  fetb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_head    (q_head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  a_queue_sane: assert property (@(posedge clk) disable iff (rst)
    !(q_status.empty && q_status.full))
    else $error("queue reports empty and full");

  a_pre_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.byte_kind == KIND_PREAMBLE || out_item.byte_kind == KIND_HEADER)
    |-> !out_item.run_last)
    else $error("preamble or header byte marked as last of transaction");

  a_pad_after_tail: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && out_item.byte_kind == KIND_FCS && !out_item.run_last
    |=> out_valid && (out_item.byte_kind == KIND_FCS || out_item.byte_kind == KIND_IDLE))
    else $error("frame tail interrupted");

endmodule

`default_nettype wire

// ----- bench/ethernet_frame_builder_crc32_tb.sv -----
// ethernet_frame_builder_crc32_tb: self-checking bench for the Ethernet framer with CRC-32 FCS.
// A byte-level framer model predicts every output transaction, with random idling on both sides.
// Depends on fetb_pkg and ethernet_frame_builder_crc32.
`default_nettype none

module ethernet_frame_builder_crc32_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fetb_pkg::*;

  localparam logic [63:0] START_WORD   = 64'hFB55_5555_5555_55D5;
  localparam logic [31:0] IEEE_POLY_R  = 32'hEDB8_8320;
  localparam logic [31:0] CRC_SEED     = 32'hFFFF_FFFF;
  localparam logic [7:0]  PAD_BYTE     = 8'h07;
  localparam logic [1:0]  CFG_NONE     = 2'd3;
  localparam int          DRAIN_CYCLES = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count = 0;

  // framer model state
  logic        mdl_in_frame = 1'b0;
  logic [31:0] mdl_crc = CRC_SEED;
  logic [1:0]  mdl_len = '0;
  logic [47:0] mdl_dest = '0;
  logic [47:0] mdl_src = '0;
  logic [15:0] mdl_etype = 16'hAEFE;

  out_item_t expected_bytes[$];

  ethernet_frame_builder_crc32 dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ IEEE_POLY_R) : (r >> 1);
    end
    return r;
  endfunction

  task automatic emit_byte(input logic [7:0] b, input logic [2:0] kind, input bit in_crc);
    out_item_t e;
    e.out_byte  = b;
    e.byte_kind = kind;
    e.run_last  = 1'b0;
    expected_bytes.insert(expected_bytes.size(), e);
    if (in_crc) mdl_crc = crc_next(mdl_crc, b);
    mdl_len = mdl_len + 2'd1;
  endtask

  task automatic predict_framer(input logic [7:0] pb, input logic last);
    logic [31:0] fcs;
    out_item_t   tail;
    if (!mdl_in_frame) begin
      mdl_crc = CRC_SEED;
      mdl_len = '0;
      for (int i = 7; i >= 0; i--) emit_byte(START_WORD[i*8 +: 8], KIND_PREAMBLE, 1'b0);
      for (int i = 5; i >= 0; i--) emit_byte(mdl_dest[i*8 +: 8], KIND_HEADER, 1'b1);
      for (int i = 5; i >= 0; i--) emit_byte(mdl_src[i*8 +: 8], KIND_HEADER, 1'b1);
      for (int i = 1; i >= 0; i--) emit_byte(mdl_etype[i*8 +: 8], KIND_HEADER, 1'b1);
      mdl_in_frame = 1'b1;
    end
    emit_byte(pb, KIND_PAYLOAD, 1'b1);
    if (last) begin
      fcs = ~mdl_crc;
      for (int i = 0; i < 4; i++) emit_byte(fcs[i*8 +: 8], KIND_FCS, 1'b0);
      while (mdl_len != 2'd0) emit_byte(PAD_BYTE, KIND_IDLE, 1'b0);
      mdl_in_frame = 1'b0;
      mdl_crc = CRC_SEED;
      mdl_len = '0;
    end
    tail = expected_bytes.pop_back();
    tail.run_last = 1'b1;
    expected_bytes.insert(expected_bytes.size(), tail);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [47:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_DEST_MAC:   mdl_dest = data;
      CFG_SRC_MAC:    mdl_src = data;
      CFG_ETHER_TYPE: mdl_etype = data[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_payload_byte(input logic [7:0] pb, input logic last);
    in_item_t it;
    it.payload_byte = pb;
    it.last_byte    = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_framer(pb, last);
  endtask

  task automatic send_frame(input int len);
    for (int i = 0; i < len; i++) begin
      send_payload_byte(8'($urandom_range(255)), (i == len - 1));
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic write_random_config();
    write_reg(CFG_DEST_MAC, rand48());
    write_reg(CFG_SRC_MAC, rand48());
    write_reg(CFG_ETHER_TYPE, rand48());
  endtask

  // Output side: check each accepted transaction, then pick the next stall.
  always @(posedge clk) begin : out_monitor
    out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected output transaction: out_byte %02h byte_kind %0d run_last %0b",
                 out_item.out_byte, out_item.byte_kind, out_item.run_last);
          fail_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_item.out_byte !== want.out_byte) begin
            $error("out_byte expected %02h actual %02h", want.out_byte, out_item.out_byte);
            fail_count++;
          end
          if (out_item.byte_kind !== want.byte_kind) begin
            $error("byte_kind expected %0d actual %0d", want.byte_kind, out_item.byte_kind);
            fail_count++;
          end
          if (out_item.run_last !== want.run_last) begin
            $error("run_last expected %0b actual %0b", want.run_last, out_item.run_last);
            fail_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic test_reset_config();
    send_frame(1);
    wait_drained();
  endtask

  task automatic test_field_extremes();
    write_reg(CFG_DEST_MAC, '1);
    write_reg(CFG_SRC_MAC, '1);
    write_reg(CFG_ETHER_TYPE, '1);
    send_payload_byte(8'hFF, 1'b1);
    wait_drained();
    write_reg(CFG_DEST_MAC, '0);
    write_reg(CFG_SRC_MAC, '0);
    write_reg(CFG_ETHER_TYPE, '0);
    send_payload_byte(8'h00, 1'b1);
    wait_drained();
  endtask

  // payload lengths 2..4 together with the single byte frames cover 0..3 pad bytes
  task automatic test_padding();
    write_random_config();
    for (int len = 2; len <= 4; len++) send_frame(len);
    wait_drained();
  endtask

  task automatic test_config_mid_frame();
    send_payload_byte(8'h5A, 1'b0);
    send_payload_byte(8'hA5, 1'b0);
    wait_drained();
    write_random_config();
    send_payload_byte(8'h3C, 1'b1);
    send_frame(1);
    wait_drained();
  endtask

  task automatic test_ignored_index();
    write_reg(CFG_NONE, rand48());
    write_reg(CFG_ETHER_TYPE, rand48());
    send_frame(1);
    wait_drained();
  endtask

  task automatic test_random_frames(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      send_frame(len);
      sent += len;
    end
    wait_drained();
  endtask

  initial begin
    send_idle_pct = 23;
    recv_idle_pct = 56;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_config();
    test_field_extremes();
    test_padding();
    test_config_mid_frame();
    test_ignored_index();

    write_random_config();
    test_random_frames(45);

    send_idle_pct = 56;
    recv_idle_pct = 23;
    write_reg(CFG_DEST_MAC, '1);
    write_reg(CFG_SRC_MAC, '0);
    write_reg(CFG_ETHER_TYPE, '0);
    test_random_frames(44);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_random_config();
    test_random_frames(44);

    if (fail_count == 0) begin
      $display("ethernet_frame_builder_crc32_tb: PASS");
    end else begin
      $display("ethernet_frame_builder_crc32_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("ethernet_frame_builder_crc32_tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
